// File: design/hmr_pkg.sv
// Shared types and constants for the haplotype mixed-radix encoder.
// No dependencies; imported by the label unit, the code memory and the top level.
package hmr_pkg;

  // Value of paddr[2] that selects the sample-count register on the configuration port.
  localparam logic ADDR_NUM_SAMPLES = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_READ,
    S_CALC,
    S_CRD,
    S_CWAIT,
    S_CLEFT,
    S_CRIGHT
  } enc_state_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_RD,
    L_CMP,
    L_INS
  } lbl_state_t;

  typedef struct packed {
    logic clear;
    logic start;
  } lbl_ctrl_t;

endpackage

// File: design/hmr_code_mem.sv
// Left and right haplotype code storage, one entry per sample.
// Uses hmr_pkg; one write port, one registered read port shared by both codes.
module hmr_code_mem import hmr_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int CODE_WIDTH = 64,
  parameter int AW = 10
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [CODE_WIDTH-1:0] rd_left,
  output logic [CODE_WIDTH-1:0] rd_right,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [CODE_WIDTH-1:0] wr_left,
  input  logic [CODE_WIDTH-1:0] wr_right
);

  logic [CODE_WIDTH-1:0] left_mem [DEPTH];
  logic [CODE_WIDTH-1:0] right_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[wr_addr]  <= wr_left;
      right_mem[wr_addr] <= wr_right;
    end
    if (rd_en) begin
      rd_left  <= left_mem[rd_addr];
      rd_right <= right_mem[rd_addr];
    end
  end

endmodule

// File: design/hmr_label_unit.sv
// Dense relabeling of codes during compaction: a code map memory with a linear scan.
// Uses hmr_pkg for the control struct and the state type.
module hmr_label_unit import hmr_pkg::*; #(
  parameter int CODE_WIDTH = 64,
  parameter int MAP_DEPTH = 2048,
  parameter int LABEL_WIDTH = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lbl_ctrl_t              ctrl,
  input  logic [CODE_WIDTH-1:0]  code,
  output logic                   done,
  output logic [LABEL_WIDTH-1:0] label,
  output logic [LABEL_WIDTH-1:0] label_count
);

  localparam int MI = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int MU = $clog2(MAP_DEPTH + 1);

  logic [CODE_WIDTH-1:0] map_mem [MAP_DEPTH];
  logic [CODE_WIDTH-1:0] rd_data;
  logic [CODE_WIDTH-1:0] code_r;
  logic [MI-1:0]         k;
  logic [MU-1:0]         used;
  logic [LABEL_WIDTH-1:0] next_label;
  lbl_state_t            state, state_next;
  logic                  map_full;
  logic                  hit;
  logic                  last_entry;
  logic                  map_we;

  assign map_full    = (32'(used) >= 32'(MAP_DEPTH));
  assign hit         = (rd_data == code_r);
  assign last_entry  = ((MU'(k) + MU'(1)) == used);
  assign label_count = next_label;

  always_comb begin
    state_next = state;
    unique case (state)
      L_IDLE: begin
        if (ctrl.start) begin
          state_next = (used == '0) ? L_INS : L_RD;
        end
      end
      L_RD: state_next = L_CMP;
      L_CMP: begin
        if (hit) begin
          state_next = L_IDLE;
        end else if (last_entry) begin
          state_next = L_INS;
        end else begin
          state_next = L_RD;
        end
      end
      L_INS: state_next = L_IDLE;
      default: state_next = L_IDLE;
    endcase
  end

  always_comb begin
    map_we = (state == L_INS) && !map_full;
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[used[MI-1:0]] <= code_r;
    end
    if (state == L_RD) begin
      rd_data <= map_mem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= L_IDLE;
      used       <= '0;
      next_label <= '0;
      done       <= 1'b0;
      k          <= '0;
    end else begin
      state <= state_next;
      done  <= ((state == L_CMP) && hit) || (state == L_INS);
      if (ctrl.clear) begin
        used       <= '0;
        next_label <= '0;
      end
      unique case (state)
        L_IDLE: begin
          if (ctrl.start) begin
            code_r <= code;
            k      <= '0;
          end
        end
        L_CMP: begin
          if (hit) begin
            label <= LABEL_WIDTH'(k);
          end else if (!last_entry) begin
            k <= k + MI'(1);
          end
        end
        L_INS: begin
          // A full map still hands out a fresh label, it just forgets the code.
          label      <= next_label;
          next_label <= next_label + LABEL_WIDTH'(1);
          if (!map_full) begin
            used <= used + MU'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: design/haplotype_mixed_radix_encoder_unit.sv
// Top level of the haplotype mixed-radix encoder: control, arithmetic, output register.
// Uses hmr_pkg, hmr_code_mem and hmr_label_unit.
//
// Usage: one input beat per sample, in sample order, carries the allele pair of
// that sample at the current locus; new_window marks the first beat of a window.
// Each input beat yields one output beat with the updated codes of that sample.
// The sample count must be written through the APB port while the block is idle; nothing enforces it.
//
// Sequencing: a beat inside a locus is accepted with the code memory read, then
// multiply-added and written back in S_CALC. The first beat of a locus also passes
// S_PREP and S_CHECK for the leaf-count product and overflow check, then S_READ. A
// compaction reads each sample (S_CRD, S_CWAIT) and relabels its codes (S_CLEFT,
// S_CRIGHT); the linear scan of the label map sets its length for each relabeled code.
// Output valid is registered in S_CALC; a new beat is accepted only in S_IDLE.
//
// Reset clears the control state, sets the leaf count to one and sets the window flag; code
// memories hold nothing valid until the first locus of a window writes them.
// The output register holds a finished beat while out_ready is low; the next
// input beat is taken meanwhile and waits in the block until the register frees.
module haplotype_mixed_radix_encoder_unit import hmr_pkg::*; #(
  parameter int MAX_SAMPLES = 1024,
  parameter int CODE_WIDTH = 64,
  parameter int MAP_DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        new_window,
  input  logic [7:0]  num_alleles,
  input  logic [7:0]  allele_l,
  input  logic [7:0]  allele_r,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  sample_index,
  output logic [63:0] left_code,
  output logic [63:0] right_code,
  output logic        is_missing,
  output logic        compacted,
  output logic        locus_done
);

  localparam int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int NW = $clog2(MAX_SAMPLES + 1);
  localparam int LW = $clog2(2 * MAX_SAMPLES + 1);
  localparam int PW = CODE_WIDTH + 8;
  localparam logic [CODE_WIDTH-1:0] MISSING = '1;

  logic [10:0]           num_samples;
  logic [NW-1:0]         n_act;
  logic [31:0]           ns32;
  enc_state_t            state, state_next;
  logic [7:0]            n_al_r, la_r, ra_r;
  logic [IW-1:0]         cnt, cnt_eff, idx_acc, idx_r, ci;
  logic                  first, comp_flag;
  logic [CODE_WIDTH-1:0] leaf;
  logic [PW-1:0]         prod;
  logic [LW-1:0]         lab_l;
  logic                  accept, out_free, need_comp, item_done, comp_last;
  logic                  rd_en, wr_en;
  logic [IW-1:0]         rd_addr, wr_addr;
  logic [CODE_WIDTH-1:0] rd_left, rd_right, wr_left, wr_right;
  logic [CODE_WIDTH-1:0] lc, rc;
  logic [PW-1:0]         lprod, rprod;
  lbl_ctrl_t             lctrl;
  logic [CODE_WIDTH-1:0] lcode;
  logic                  ldone;
  logic [LW-1:0]         llabel, lcount;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_NUM_SAMPLES) ? 32'(num_samples) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples <= 11'd1;
    end else if (psel && penable && pwrite && (paddr[2] == ADDR_NUM_SAMPLES)) begin
      num_samples <= pwdata[10:0];
    end
  end

  // A sample count of zero acts as one, any count beyond the memory as its depth.
  always_comb begin
    ns32 = 32'(num_samples);
    if (ns32 == 32'd0) begin
      ns32 = 32'd1;
    end else if (ns32 > 32'(MAX_SAMPLES)) begin
      ns32 = 32'(MAX_SAMPLES);
    end
    n_act = NW'(ns32);
  end

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign cnt_eff   = new_window ? '0 : cnt;
  assign idx_acc   = (32'(cnt_eff) >= 32'(n_act)) ? IW'(32'(n_act) - 32'd1) : cnt_eff;
  assign need_comp = !first && (n_al_r != 8'd0) && (prod >= PW'(MISSING)) && !comp_flag;
  assign item_done = (32'(cnt) + 32'd1) >= 32'(n_act);
  assign comp_last = (32'(ci) + 32'd1) >= 32'(n_act);

  // Code update from the registered memory read.
  assign lprod = PW'(rd_left) * PW'(n_al_r);
  assign rprod = PW'(rd_right) * PW'(n_al_r);

  always_comb begin
    if (first) begin
      lc = CODE_WIDTH'(la_r);
      rc = CODE_WIDTH'(ra_r);
      if ((la_r == n_al_r) || (ra_r == n_al_r)) begin
        lc = MISSING;
        rc = MISSING;
      end
    end else if ((rd_left == MISSING) || (la_r == n_al_r) || (ra_r == n_al_r)) begin
      lc = MISSING;
      rc = MISSING;
    end else begin
      lc = CODE_WIDTH'(lprod + PW'(la_r));
      rc = CODE_WIDTH'(rprod + PW'(ra_r));
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (cnt_eff == '0) ? S_PREP : S_CALC;
        end
      end
      S_PREP:  state_next = S_CHECK;
      S_CHECK: state_next = need_comp ? S_CRD : S_READ;
      S_READ:  state_next = S_CALC;
      S_CALC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_CRD:   state_next = S_CWAIT;
      S_CWAIT: state_next = (rd_left == MISSING) ? (comp_last ? S_PREP : S_CRD) : S_CLEFT;
      S_CLEFT: begin
        if (ldone) begin
          state_next = S_CRIGHT;
        end
      end
      S_CRIGHT: begin
        if (ldone) begin
          state_next = comp_last ? S_PREP : S_CRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == S_IDLE);
    rd_en       = 1'b0;
    rd_addr     = idx_r;
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    wr_left     = lc;
    wr_right    = rc;
    lctrl.clear = 1'b0;
    lctrl.start = 1'b0;
    lcode       = rd_left;
    unique case (state)
      S_IDLE: begin
        rd_en   = in_valid;
        rd_addr = idx_acc;
      end
      S_CHECK: lctrl.clear = need_comp;
      S_READ:  rd_en = 1'b1;
      S_CALC:  wr_en = out_free;
      S_CRD: begin
        rd_en   = 1'b1;
        rd_addr = ci;
      end
      S_CWAIT: lctrl.start = (rd_left != MISSING);
      S_CLEFT: begin
        lctrl.start = ldone;
        lcode       = rd_right;
      end
      S_CRIGHT: begin
        wr_en    = ldone;
        wr_addr  = ci;
        wr_left  = CODE_WIDTH'(lab_l);
        wr_right = CODE_WIDTH'(llabel);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      first     <= 1'b1;
      leaf      <= CODE_WIDTH'(1);
      comp_flag <= 1'b0;
      out_valid <= 1'b0;
      ci        <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && (state != S_CALC)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            n_al_r <= num_alleles;
            la_r   <= allele_l;
            ra_r   <= allele_r;
            idx_r  <= idx_acc;
            if (new_window) begin
              first <= 1'b1;
              leaf  <= CODE_WIDTH'(1);
              cnt   <= '0;
            end
            if (cnt_eff == '0) begin
              comp_flag <= 1'b0;
            end
          end
        end
        S_PREP:  prod <= PW'(leaf) * PW'(n_al_r);
        S_CHECK: begin
          if (need_comp) begin
            ci <= '0;
          end else begin
            leaf <= prod[CODE_WIDTH-1:0];
          end
        end
        S_CALC: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            sample_index <= 10'(idx_r);
            left_code    <= 64'(lc);
            right_code   <= 64'(rc);
            is_missing   <= (lc == MISSING);
            compacted    <= comp_flag;
            locus_done   <= item_done;
            if (item_done) begin
              cnt   <= '0;
              first <= 1'b0;
            end else begin
              cnt <= cnt + IW'(1);
            end
          end
        end
        S_CWAIT: begin
          if ((rd_left == MISSING) && comp_last) begin
            comp_flag <= 1'b1;
            leaf      <= CODE_WIDTH'(lcount);
          end else if (rd_left == MISSING) begin
            ci <= ci + IW'(1);
          end
        end
        S_CLEFT: begin
          if (ldone) begin
            lab_l <= llabel;
          end
        end
        S_CRIGHT: begin
          if (ldone) begin
            if (comp_last) begin
              comp_flag <= 1'b1;
              leaf      <= CODE_WIDTH'(lcount + LW'(0));
            end else begin
              ci <= ci + IW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  hmr_code_mem #(
    .DEPTH(MAX_SAMPLES),
    .CODE_WIDTH(CODE_WIDTH),
    .AW(IW)
  ) u_code_mem (
    .clk(clk),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_left(rd_left),
    .rd_right(rd_right),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_left(wr_left),
    .wr_right(wr_right)
  );

  hmr_label_unit #(
    .CODE_WIDTH(CODE_WIDTH),
    .MAP_DEPTH(MAP_DEPTH),
    .LABEL_WIDTH(LW)
  ) u_label (
    .clk(clk),
    .rst(rst),
    .ctrl(lctrl),
    .code(lcode),
    .done(ldone),
    .label(llabel),
    .label_count(lcount)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for haplotype_mixed_radix_encoder_unit.
// Depends on hmr_pkg and the encoder RTL; an internal code predictor supplies the expectations.
`timescale 1ns / 100ps

module testbench;
  import hmr_pkg::*;

  localparam int NSAMP_MAX = 1024;
  localparam int LABEL_DEPTH = 2048;
  localparam logic [63:0] MISSING_CODE = '1;

  typedef struct {
    logic [9:0]  idx;
    logic [63:0] lc;
    logic [63:0] rc;
    logic        miss;
    logic        comp;
    logic        done;
  } code_beat_t;

  typedef struct {
    logic        nw;
    logic [7:0]  nal;
    logic [7:0]  la;
    logic [7:0]  ra;
    bit          known;
    logic [63:0] elc;
    logic [63:0] erc;
    logic        emiss;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        new_window = 1'b0;
  logic [7:0]  num_alleles = 8'd1, allele_l = '0, allele_r = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  sample_index;
  logic [63:0] left_code, right_code;
  logic        is_missing, compacted, locus_done;

  haplotype_mixed_radix_encoder_unit dut (.*);

  always #2 clk = ~clk;

  // Predictor state.
  logic [10:0] cfg_samples = 11'd1;
  logic [63:0] pl_codes [NSAMP_MAX];
  logic [63:0] pr_codes [NSAMP_MAX];
  logic [63:0] leaf_cnt = 64'd1;
  int          samp_cnt = 0;
  bit          first_locus = 1'b1;
  bit          locus_comp = 1'b0;
  int          label_of_code [logic [63:0]];
  int          labels_stored, label_next;

  code_beat_t  expected_beats [$];
  int          errors = 0;
  int          beats_in = 0, beats_out = 0, compactions = 0;
  int          send_idle_pct = 0, recv_idle_pct = 0;
  bit          pressure_done = 1'b0;

  function automatic int active_samples();
    if (cfg_samples == 0) return 1;
    if (cfg_samples > NSAMP_MAX) return NSAMP_MAX;
    return int'(cfg_samples);
  endfunction

  function automatic logic [63:0] relabel(logic [63:0] code);
    if (label_of_code.exists(code)) return 64'(label_of_code[code]);
    if (labels_stored < LABEL_DEPTH) begin
      label_of_code[code] = label_next;
      labels_stored++;
    end
    label_next++;
    return 64'(label_next - 1);
  endfunction

  task automatic compact_codes();
    label_of_code.delete();
    labels_stored = 0;
    label_next = 0;
    for (int i = 0; i < active_samples(); i++) begin
      if (pl_codes[i] == MISSING_CODE) continue;
      pl_codes[i] = relabel(pl_codes[i]);
      pr_codes[i] = relabel(pr_codes[i]);
    end
    leaf_cnt = 64'(label_next);
    compactions++;
  endtask

  task automatic encode_sample(input logic nw, input logic [7:0] nal, input logic [7:0] la,
                               input logic [7:0] ra, output code_beat_t b);
    int n;
    int idx;
    n = active_samples();
    if (nw) begin
      first_locus = 1'b1;
      leaf_cnt = 64'd1;
      samp_cnt = 0;
    end
    if (samp_cnt == 0) begin
      locus_comp = 1'b0;
      if (!first_locus && nal != 0 && leaf_cnt > (MISSING_CODE - 64'd1) / 64'(nal)) begin
        compact_codes();
        locus_comp = 1'b1;
      end
      leaf_cnt = leaf_cnt * 64'(nal);
    end
    idx = (samp_cnt >= n) ? n - 1 : samp_cnt;
    if (first_locus) begin
      b.lc = 64'(la);
      b.rc = 64'(ra);
      if (la == nal || ra == nal) begin
        b.lc = MISSING_CODE;
        b.rc = MISSING_CODE;
      end
    end else if (pl_codes[idx] == MISSING_CODE || la == nal || ra == nal) begin
      b.lc = MISSING_CODE;
      b.rc = MISSING_CODE;
    end else begin
      b.lc = pl_codes[idx] * 64'(nal) + 64'(la);
      b.rc = pr_codes[idx] * 64'(nal) + 64'(ra);
    end
    pl_codes[idx] = b.lc;
    pr_codes[idx] = b.rc;
    b.idx = idx[9:0];
    b.miss = (b.lc == MISSING_CODE);
    b.comp = locus_comp;
    b.done = (samp_cnt + 1 >= n);
    if (b.done) begin
      samp_cnt = 0;
      first_locus = 1'b0;
    end else begin
      samp_cnt++;
    end
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] exp);
    $display("ERROR @%0t beat %0d: %s got %0h expected %0h", $realtime, beats_out, what, got, exp);
    errors++;
  endtask

  // Offer one beat; a known row overrides the predicted code fields.
  task automatic send_beat(input stim_row_t r);
    code_beat_t b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    new_window <= r.nw;
    num_alleles <= r.nal;
    allele_l <= r.la;
    allele_r <= r.ra;
    do @(posedge clk); while (!in_ready);
    encode_sample(r.nw, r.nal, r.la, r.ra, b);
    if (r.known) begin
      b.lc = r.elc;
      b.rc = r.erc;
      b.miss = r.emiss;
    end
    expected_beats.push_back(b);
    beats_in++;
    if (beats_in < 620) begin
      send_idle_pct = 7;
      recv_idle_pct = 67;
    end else if (beats_in < 1240) begin
      send_idle_pct = 67;
      recv_idle_pct = 7;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_samples(input logic [10:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(ADDR_NUM_SAMPLES);
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_samples = value;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_allele(logic [7:0] nal);
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return nal;
    if (roll < 15 || nal == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(int'(nal) - 1));
  endfunction

  function automatic logic [7:0] pick_count();
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return 8'd0;
    if (roll < 8) return 8'd1;
    if (roll < 25) return 8'd255;
    return 8'($urandom_range(255, 2));
  endfunction

  // Windows of whole loci with random content; a few windows restart mid-locus.
  task automatic random_phase(input int count, input int max_loci);
    stim_row_t r;
    int loci_left;
    logic [7:0] nal;
    loci_left = 0;
    nal = 8'd2;
    r.known = 1'b0;
    for (int k = 0; k < count || samp_cnt != 0; k++) begin
      r.nw = 1'b0;
      if (samp_cnt == 0) begin
        if (loci_left == 0) begin
          r.nw = 1'b1;
          loci_left = $urandom_range(max_loci, 1);
        end
        loci_left--;
        nal = pick_count();
      end else if ($urandom_range(99) < 2) begin
        r.nw = 1'b1;
        loci_left = $urandom_range(max_loci, 1) - 1;
        nal = pick_count();
      end
      r.nal = nal;
      r.la = pick_allele(nal);
      r.ra = pick_allele(nal);
      send_beat(r);
    end
  endtask

  // Receiver: random back-pressure plus one long hold once traffic is under way.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (!pressure_done && beats_in >= 300) begin
        pressure_done = 1'b1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    code_beat_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        report("unexpected beat, sample", 64'(sample_index), 64'd0);
      end else begin
        e = expected_beats.pop_front();
        if (sample_index !== e.idx) report("sample_index", 64'(sample_index), 64'(e.idx));
        if (left_code !== e.lc) report("left_code", left_code, e.lc);
        if (right_code !== e.rc) report("right_code", right_code, e.rc);
        if (is_missing !== e.miss) report("is_missing", 64'(is_missing), 64'(e.miss));
        if (compacted !== e.comp) report("compacted", 64'(compacted), 64'(e.comp));
        if (locus_done !== e.done) report("locus_done", 64'(locus_done), 64'(e.done));
      end
      beats_out++;
    end
  end

  initial begin
    #2400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    stim_row_t dir [$];
    stim_row_t r;
    for (int i = 0; i < NSAMP_MAX; i++) begin
      pl_codes[i] = '0;
      pr_codes[i] = '0;
    end
    // One sample per locus after reset: first-locus codes, missing, zero alleles,
    // out-of-range alleles, then wide loci until the leaf count forces a relabel.
    dir.push_back('{1'b1, 8'd255, 8'd0, 8'd254, 1'b1, 64'd0, 64'd254, 1'b0});
    dir.push_back('{1'b0, 8'd255, 8'd255, 8'd0, 1'b1, MISSING_CODE, MISSING_CODE, 1'b1});
    dir.push_back('{1'b1, 8'd2, 8'd1, 8'd0, 1'b1, 64'd1, 64'd0, 1'b0});
    dir.push_back('{1'b0, 8'd0, 8'd5, 8'd7, 1'b1, 64'd5, 64'd7, 1'b0});
    dir.push_back('{1'b0, 8'd0, 8'd0, 8'd3, 1'b1, MISSING_CODE, MISSING_CODE, 1'b1});
    dir.push_back('{1'b1, 8'd3, 8'd7, 8'd200, 1'b1, 64'd7, 64'd200, 1'b0});
    dir.push_back('{1'b0, 8'd1, 8'd0, 8'd0, 1'b0, '0, '0, 1'b0});
    for (int i = 0; i < 10; i++)
      dir.push_back('{1'b0, 8'd255, 8'd254, 8'(i), 1'b0, '0, '0, 1'b0});
    dir.push_back('{1'b0, 8'd128, 8'd255, 8'd127, 1'b0, '0, '0, 1'b0});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (dir[i]) send_beat(dir[i]);
    drain();

    write_samples(11'd0);
    random_phase(60, 12);
    drain();
    write_samples(11'd3);
    random_phase(200, 14);
    drain();
    // Full sample count: a single locus keeps the run short.
    write_samples(11'd1024);
    r.known = 1'b0;
    for (int i = 0; i < NSAMP_MAX; i++) begin
      r.nw = (i == 0);
      r.nal = 8'd255;
      r.la = pick_allele(8'd255);
      r.ra = pick_allele(8'd255);
      send_beat(r);
    end
    drain();
    write_samples(11'd16);
    random_phase(200, 12);
    drain();
    write_samples(11'd7);
    random_phase(150, 12);
    drain();
    write_samples(11'd2);
    random_phase(100, 14);
    drain();
    write_samples(11'd5);
    random_phase(100, 12);
    drain();

    $display("Run covered %0d sample beats in, %0d out, %0d relabel passes.",
             beats_in, beats_out, compactions);
    $display("Sample counts 0, 1, 2, 3, 5, 7, 16 and 1024 with random back-pressure.");
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
